@@ rtl/particle_bounce_sprite_step_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the particle sprite step unit
// Implication checks in the current and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_BOUNCE_SPRITE_STEP_UNIT_MACROS_SVH
`define PARTICLE_BOUNCE_SPRITE_STEP_UNIT_MACROS_SVH

// a holds -> c holds in the same cycle
`define PBS_ASSERT_NOW(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error(msg);

// a holds -> c holds in the next cycle
`define PBS_ASSERT_NEXT(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/pbs_pkg.sv @@
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared constants and arithmetic helpers of the particle sprite step unit.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int unsigned PARTICLES_DEFAULT = 16384;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_INV_HALF_W   = 2'd2;
  localparam logic [1:0] REG_TIME_STEP    = 2'd3;

  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd320;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd320;
  localparam logic [30:0] INV_HALF_W_RST   = 31'd409;
  localparam logic [30:0] TIME_STEP_RST    = 31'd1092;

  localparam logic [16:0] CORNER_U_MAG = 17'd113512;

  localparam logic [1:0] CORNER_LEFT  = 2'd0;
  localparam logic [1:0] CORNER_TOP   = 2'd1;
  localparam logic [1:0] CORNER_RIGHT = 2'd2;

  localparam int unsigned ENTRY_W = 32 * 4 + 16 + 24;

  function automatic logic signed [18:0] tex_u_of(input logic [1:0] c);
    logic signed [18:0] r;
    r = 19'sd0;
    if (c == CORNER_LEFT)  r = 19'sd113512;
    if (c == CORNER_RIGHT) r = -19'sd113512;
    return r;
  endfunction

  function automatic logic signed [18:0] tex_v_of(input logic [1:0] c);
    logic signed [18:0] r;
    r = -19'sd65536;
    if (c == CORNER_TOP) r = 19'sd131072;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    if (v < -66'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction

  function automatic logic signed [31:0] bounce(input logic signed [31:0] vel,
                                                input logic signed [31:0] np,
                                                input logic [15:0] rad,
                                                input logic [12:0] wall);
    logic signed [31:0] v;
    logic signed [33:0] np_w;
    logic signed [33:0] lim;
    v    = vel;
    np_w = 34'(np);
    lim  = $signed({5'b0, wall, 16'b0}) - $signed({18'b0, rad});
    if (np_w < $signed({18'b0, rad})) begin
      if (v < 0) v = (v == 32'sh80000000) ? 32'sh7fffffff : -v;
    end
    if (np_w >= lim) begin
      if (v > 0) v = -v;
    end
    return v;
  endfunction

endpackage

@@ rtl/pbs_ifs.sv @@
// ----------------------------------------------------------------------------
// pbs channel interfaces
// Input item, vertex result and configuration write channels.
// ----------------------------------------------------------------------------
interface pbs_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [13:0] particle_index;
  logic signed [31:0] load_pos_x;
  logic signed [31:0] load_pos_y;
  logic signed [31:0] load_vel_x;
  logic signed [31:0] load_vel_y;
  logic [15:0] load_radius;
  logic [7:0]  load_red;
  logic [7:0]  load_green;
  logic [7:0]  load_blue;
  modport source (output valid, kind, particle_index, load_pos_x, load_pos_y, load_vel_x,
                  load_vel_y, load_radius, load_red, load_green, load_blue, input ready);
  modport sink (input valid, kind, particle_index, load_pos_x, load_pos_y, load_vel_x,
                load_vel_y, load_radius, load_red, load_green, load_blue, output ready);
endinterface

interface pbs_vertex_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [18:0] tex_u;
  logic signed [18:0] tex_v;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [13:0] source_index;
  logic [1:0]  corner;
  logic        last;
  modport source (output valid, vertex_x, vertex_y, tex_u, tex_v, out_red, out_green,
                  out_blue, source_index, corner, last, input ready);
  modport sink (input valid, vertex_x, vertex_y, tex_u, tex_v, out_red, out_green,
                out_blue, source_index, corner, last, output ready);
endinterface

interface pbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pbs_ram.sv @@
// ----------------------------------------------------------------------------
// pbs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/pbs_front.sv @@
// ----------------------------------------------------------------------------
// pbs_front
// Accepts items, drops out of range indexes, queues the rest two deep.
// ----------------------------------------------------------------------------
module pbs_front #(
  parameter int unsigned PARTICLES = pbs_pkg::PARTICLES_DEFAULT,
  localparam int unsigned AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1,
  localparam int unsigned QW = 1 + 14 + AW + pbs_pkg::ENTRY_W
) (
  input  logic          clk,
  input  logic          rst,
  pbs_item_if.sink      req,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [QW-1:0] q_data
);
  logic [QW-1:0] slot [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  logic          push;
  logic          pop;
  logic          in_range;
  logic [16:0]   idx_w;

  assign idx_w    = {3'b0, req.particle_index};
  assign in_range = idx_w < 17'(PARTICLES);
  assign req.ready = cnt != 2'd2;
  assign push     = req.valid && req.ready && in_range;
  assign pop      = q_valid && q_ready;
  assign q_valid  = cnt != 2'd0;
  assign q_data   = slot[rp];

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) cnt_next = cnt + 2'd1;
    if (pop && !push) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= {req.kind, req.particle_index, idx_w[AW-1:0],
                   req.load_pos_x, req.load_pos_y, req.load_vel_x, req.load_vel_y,
                   req.load_radius, req.load_red, req.load_green, req.load_blue};
    end
  end
endmodule

@@ rtl/pbs_back.sv @@
// ----------------------------------------------------------------------------
// pbs_back
// Executes queued items: loads the table, or reads, moves and emits a sprite.
// ----------------------------------------------------------------------------
`include "particle_bounce_sprite_step_unit_macros.svh"

module pbs_back #(
  parameter int unsigned PARTICLES = pbs_pkg::PARTICLES_DEFAULT,
  localparam int unsigned AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1,
  localparam int unsigned QW = 1 + 14 + AW + pbs_pkg::ENTRY_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [QW-1:0]               q_data,
  pbs_cfg_if.sink                     cfg,
  pbs_vertex_if.source                vtx,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [pbs_pkg::ENTRY_W-1:0] ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  logic [pbs_pkg::ENTRY_W-1:0] ram_rdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_E0   = 3'd3;
  localparam logic [2:0] S_E1   = 3'd4;
  localparam logic [2:0] S_E2   = 3'd5;

  logic [2:0]  state;
  logic [2:0]  state_next;

  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [30:0] inv_half_w;
  logic [30:0] time_step;

  logic                        q_kind;
  logic [13:0]                 q_index;
  logic [AW-1:0]               q_addr;
  logic [pbs_pkg::ENTRY_W-1:0] q_entry;

  logic [13:0]   index;
  logic [AW-1:0] addr;
  logic signed [31:0] px, py, vx, vy;
  logic [15:0] rad;
  logic [23:0] col;
  logic signed [64:0] pcx, pcy;
  logic signed [63:0] pmx, pmy;
  logic [32:0] pu;
  logic signed [31:0] cx, cy;

  logic signed [31:0] r_px, r_py, r_vx, r_vy;
  logic signed [32:0] dx, dy;
  logic signed [64:0] sx, sy;
  logic signed [31:0] npx, npy, nvx, nvy;

  logic [1:0]         emit_corner;
  logic signed [33:0] off_x, off_y;
  logic               emit_go;

  assign {q_kind, q_index, q_addr, q_entry} = q_data;
  assign {r_px, r_py, r_vx, r_vy} = ram_rdata[pbs_pkg::ENTRY_W-1:40];

  assign q_ready   = state == S_IDLE;
  assign ram_raddr = q_addr;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= pbs_pkg::FRAME_WIDTH_RST;
      frame_height <= pbs_pkg::FRAME_HEIGHT_RST;
      inv_half_w   <= pbs_pkg::INV_HALF_W_RST;
      time_step    <= pbs_pkg::TIME_STEP_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pbs_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data[12:0];
        pbs_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data[12:0];
        pbs_pkg::REG_INV_HALF_W:   inv_half_w   <= cfg.data;
        pbs_pkg::REG_TIME_STEP:    time_step    <= cfg.data;
      endcase
    end
  end

  // centring and motion products
  assign dx = $signed({r_px[31], r_px}) - $signed({5'b0, frame_width, 15'b0});
  assign dy = $signed({r_py[31], r_py}) - $signed({5'b0, frame_height, 15'b0});

  // sums, saturation and bounce
  assign sx  = 65'(pmx >>> 16) + 65'(px);
  assign sy  = 65'(pmy >>> 16) + 65'(py);
  assign npx = pbs_pkg::sat32(66'(sx));
  assign npy = pbs_pkg::sat32(66'(sy));
  assign nvx = pbs_pkg::bounce(vx, npx, rad, frame_width);
  assign nvy = pbs_pkg::bounce(vy, npy, rad, frame_height);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = q_addr;
    ram_wdata = q_entry;
    if (state == S_IDLE && q_valid && q_kind == pbs_pkg::KIND_LOAD) begin
      ram_we = 1'b1;
    end else if (state == S_SUM) begin
      ram_we    = 1'b1;
      ram_waddr = addr;
      ram_wdata = {npx, npy, nvx, nvy, rad, col};
    end
  end

  always_comb begin
    emit_corner = pbs_pkg::CORNER_LEFT;
    if (state == S_E1) emit_corner = pbs_pkg::CORNER_TOP;
    if (state == S_E2) emit_corner = pbs_pkg::CORNER_RIGHT;
    unique case (emit_corner)
      pbs_pkg::CORNER_LEFT:  off_x = $signed({1'b0, pu}) >>> 16;
      pbs_pkg::CORNER_TOP:   off_x = 34'sd0;
      default:               off_x = (-$signed({1'b0, pu})) >>> 16;
    endcase
    if (emit_corner == pbs_pkg::CORNER_TOP) off_y = $signed({17'b0, rad, 1'b0});
    else                                    off_y = -$signed({18'b0, rad});
  end

  assign emit_go = (state == S_E0 || state == S_E1 || state == S_E2) &&
                   (!vtx.valid || vtx.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid && q_kind == pbs_pkg::KIND_STEP) state_next = S_MUL;
      S_MUL:  state_next = S_SUM;
      S_SUM:  state_next = S_E0;
      S_E0:   if (emit_go) state_next = S_E1;
      S_E1:   if (emit_go) state_next = S_E2;
      S_E2:   if (emit_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vtx.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go)        vtx.valid <= 1'b1;
      else if (vtx.ready) vtx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      index <= q_index;
      addr  <= q_addr;
    end
    if (state == S_MUL) begin
      px  <= r_px;
      py  <= r_py;
      vx  <= r_vx;
      vy  <= r_vy;
      rad <= ram_rdata[39:24];
      col <= ram_rdata[23:0];
      pcx <= dx * $signed({1'b0, inv_half_w});
      pcy <= dy * $signed({1'b0, inv_half_w});
      pmx <= r_vx * $signed({1'b0, time_step});
      pmy <= r_vy * $signed({1'b0, time_step});
      pu  <= {17'b0, ram_rdata[39:24]} * {16'b0, pbs_pkg::CORNER_U_MAG};
    end
    if (state == S_SUM) begin
      cx <= pbs_pkg::sat32(66'(pcx >>> 16));
      cy <= pbs_pkg::sat32(66'(pcy >>> 16));
    end
    if (emit_go) begin
      vtx.vertex_x     <= pbs_pkg::sat32(66'(off_x) + 66'(cx));
      vtx.vertex_y     <= pbs_pkg::sat32(66'(off_y) + 66'(cy));
      vtx.tex_u        <= pbs_pkg::tex_u_of(emit_corner);
      vtx.tex_v        <= pbs_pkg::tex_v_of(emit_corner);
      vtx.out_red      <= col[23:16];
      vtx.out_green    <= col[15:8];
      vtx.out_blue     <= col[7:0];
      vtx.source_index <= index;
      vtx.corner       <= emit_corner;
      vtx.last         <= emit_corner == pbs_pkg::CORNER_RIGHT;
    end
  end

  `PBS_ASSERT_NEXT(a_sum_to_emit, clk, rst, state == S_SUM, state == S_E0, "sum must emit")
  `PBS_ASSERT_NOW(a_we_state, clk, rst, ram_we, state == S_IDLE || state == S_SUM,
                  "table write outside load or write-back")
  `PBS_ASSERT_NOW(a_pop_idle, clk, rst, q_valid && q_ready, state == S_IDLE,
                  "queue popped while busy")
endmodule

@@ rtl/particle_bounce_sprite_step_unit.sv @@
// ----------------------------------------------------------------------------
// particle_bounce_sprite_step_unit
// Particle table with Euler step, wall bounce and three sprite vertices.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     item
//  req      in   valid/ready   load or step of one particle
//  vtx      out  valid/ready   one triangle vertex, last on corner 2
//  cfg      in   valid/ready   register write, ready always high
//
//  Load item: written to the table as it leaves the queue. Step item: table
//  read, multiply, sum and write-back, then three vertex states that wait
//  on vtx; the one-item execute sequencer takes no new item until done.
//  A two-entry queue takes items while the back end works or vtx stalls.
//  Synchronous reset; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module particle_bounce_sprite_step_unit #(
  parameter int unsigned PARTICLES = pbs_pkg::PARTICLES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  pbs_item_if.sink      req,
  pbs_vertex_if.source  vtx,
  pbs_cfg_if.sink       cfg
);
  localparam int unsigned AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int unsigned QW = 1 + 14 + AW + pbs_pkg::ENTRY_W;

  logic                        q_valid;
  logic                        q_ready;
  logic [QW-1:0]               q_data;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [pbs_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [pbs_pkg::ENTRY_W-1:0] ram_rdata;

  pbs_front #(.PARTICLES(PARTICLES)) u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  pbs_back #(.PARTICLES(PARTICLES)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .cfg(cfg), .vtx(vtx),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr), .ram_rdata(ram_rdata)
  );

  pbs_ram #(.WIDTH(pbs_pkg::ENTRY_W), .DEPTH(PARTICLES)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
endmodule
